FILE: sv/sssc_pkg.sv
// Shared types, constants and the segment table for the seven-segment shift chain driver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sssc_pkg;

  localparam int OPCODE_W = 2;
  localparam int VALUE_W  = 20;
  localparam int SEG_W    = 8;
  localparam int SLOT_W   = 4;
  localparam int DIGIT_W  = 4;

  // decimal digits needed for any VALUE_W-bit value, and the widest group allowed
  localparam int CONV_DIGITS = 7;
  localparam int MAX_DIGITS  = 8;
  localparam int ITER_W      = $clog2(VALUE_W);

  localparam int LEVEL_DIGITS_DEF = 2;
  localparam int ROWS_DIGITS_DEF  = 4;
  localparam int SCORE_DIGITS_DEF = 6;

  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [OPCODE_W-1:0] {
    GRP_LEVEL = 2'd0,
    GRP_ROWS  = 2'd1,
    GRP_SCORE = 2'd2
  } grp_e;

  typedef struct packed {
    grp_e               grp;
    logic [VALUE_W-1:0] value;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_CONV,
    BK_COMMIT
  } back_state_e;

  // segments a-g in bits 0-6, decimal point (bit 7) off
  function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
    logic [SEG_W-1:0] seg;
    case (digit)
      4'd0: seg = 8'h3F;
      4'd1: seg = 8'h06;
      4'd2: seg = 8'h5B;
      4'd3: seg = 8'h4F;
      4'd4: seg = 8'h66;
      4'd5: seg = 8'h6D;
      4'd6: seg = 8'h7D;
      4'd7: seg = 8'h07;
      4'd8: seg = 8'h7F;
      4'd9: seg = 8'h6F;
      default: seg = 8'h00;
    endcase
    return seg;
  endfunction

endpackage

`default_nettype wire

FILE: sv/sssc_front.sv
// Input side: accepts transactions, drops the unused opcode and holds one command for the queue.
// Depends on sssc_pkg.
`default_nettype none

module sssc_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [sssc_pkg::OPCODE_W-1:0] opcode_i,
  input  wire logic [sssc_pkg::VALUE_W-1:0]  new_value_i,
  input  wire sssc_pkg::q_status_t           q_status_i,
  output logic                               q_push_o,
  output sssc_pkg::cmd_t                     q_wr_data_o
);
  import sssc_pkg::*;

  logic fr_valid_q, fr_valid_d;
  cmd_t fr_cmd_q;
  logic accept;
  logic op_ok;
  grp_e op_grp;

  always_comb begin
    op_ok  = 1'b1;
    op_grp = GRP_LEVEL;
    case (opcode_i)
      GRP_LEVEL: op_grp = GRP_LEVEL;
      GRP_ROWS:  op_grp = GRP_ROWS;
      GRP_SCORE: op_grp = GRP_SCORE;
      default:   op_ok  = 1'b0;
    endcase
  end

  assign full_o   = fr_valid_q && q_status_i.full;
  assign accept   = push_i && !full_o;
  assign q_push_o = fr_valid_q && !q_status_i.full;
  assign q_wr_data_o = fr_cmd_q;

  // an unused opcode is taken and dropped: no state change, no bytes
  assign fr_valid_d = (fr_valid_q && q_status_i.full) || (accept && op_ok);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fr_valid_q <= 1'b0;
    end else begin
      fr_valid_q <= fr_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && op_ok) begin
      fr_cmd_q.grp   <= op_grp;
      fr_cmd_q.value <= new_value_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sssc_queue.sv
// Short command queue between the front and the back.
// Depends on sssc_pkg.
`default_nettype none

module sssc_queue (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire sssc_pkg::cmd_t wr_data_i,
  input  wire logic           pop_i,
  output sssc_pkg::cmd_t      rd_data_o,
  output sssc_pkg::q_status_t status_o
);
  import sssc_pkg::*;

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries_q [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == CNT_W'(QUEUE_DEPTH));
  assign status_o.empty = (count_q == '0);
  assign do_push   = push_i && !status_o.full;
  assign do_pop    = pop_i && !status_o.empty;
  assign rd_data_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      entries_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

FILE: sv/sssc_back.sv
// Back end: bit-serial binary to decimal conversion, displayed digit store and byte emitter.
// Depends on sssc_pkg.
`default_nettype none

module sssc_back #(
  parameter int LEVEL_DIGITS = sssc_pkg::LEVEL_DIGITS_DEF,
  parameter int ROWS_DIGITS  = sssc_pkg::ROWS_DIGITS_DEF,
  parameter int SCORE_DIGITS = sssc_pkg::SCORE_DIGITS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire sssc_pkg::q_status_t         q_status_i,
  input  wire sssc_pkg::cmd_t              q_rd_data_i,
  output logic                             q_pop_o,
  input  wire logic                        pop_i,
  output logic                             empty_o,
  output logic [sssc_pkg::SEG_W-1:0]       segment_byte_o,
  output logic [sssc_pkg::SLOT_W-1:0]      digit_slot_o,
  output logic                             last_o
);
  import sssc_pkg::*;

  localparam int TOTAL = LEVEL_DIGITS + ROWS_DIGITS + SCORE_DIGITS;
  localparam int CNT_W = $clog2(TOTAL);

  // converter
  back_state_e                         state_q, state_d;
  logic [ITER_W-1:0]                   iter_q, iter_d;
  logic [VALUE_W-1:0]                  bin_q;
  logic [CONV_DIGITS-1:0][DIGIT_W-1:0] bcd_q;
  logic [CONV_DIGITS-1:0][DIGIT_W-1:0] bcd_adj;
  logic [CONV_DIGITS*DIGIT_W-1:0]      bcd_flat;
  logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  bcd_pad;
  grp_e                                grp_q;
  logic                                conv_load, conv_step, commit_fire;

  // displayed digits, index 0 is the least significant
  logic [LEVEL_DIGITS-1:0][DIGIT_W-1:0] level_q, level_d;
  logic [ROWS_DIGITS-1:0][DIGIT_W-1:0]  rows_q, rows_d;
  logic [SCORE_DIGITS-1:0][DIGIT_W-1:0] score_q, score_d;

  // emitter, snapshot index 0 is the next byte out
  logic [TOTAL-1:0][DIGIT_W-1:0] snap_q, snap_d;
  logic                          emit_busy_q, emit_busy_d;
  logic [CNT_W-1:0]              emit_cnt_q, emit_cnt_d;
  logic                          emit_adv, emit_last;

  // output register
  logic              out_valid_q, out_valid_d;
  logic [SEG_W-1:0]  seg_q;
  logic [SLOT_W-1:0] slot_q;
  logic              last_q;

  // shift-add-3 step, one input bit per cycle
  always_comb begin
    for (int k = 0; k < CONV_DIGITS; k++) begin
      bcd_adj[k] = (bcd_q[k] >= 4'd5) ? bcd_q[k] + 4'd3 : bcd_q[k];
    end
  end
  assign bcd_flat = bcd_adj;
  assign bcd_pad  = (MAX_DIGITS*DIGIT_W)'(bcd_q);

  always_comb begin
    state_d = state_q;
    iter_d  = iter_q;
    case (state_q)
      BK_IDLE: begin
        if (!q_status_i.empty) begin
          state_d = BK_CONV;
          iter_d  = '0;
        end
      end
      BK_CONV: begin
        iter_d = iter_q + 1'b1;
        if (iter_q == ITER_W'(VALUE_W - 1)) begin
          state_d = BK_COMMIT;
        end
      end
      BK_COMMIT: begin
        if (!emit_busy_q) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  always_comb begin
    q_pop_o     = 1'b0;
    conv_load   = 1'b0;
    conv_step   = 1'b0;
    commit_fire = 1'b0;
    case (state_q)
      BK_IDLE: begin
        q_pop_o   = !q_status_i.empty;
        conv_load = !q_status_i.empty;
      end
      BK_CONV:   conv_step   = 1'b1;
      BK_COMMIT: commit_fire = !emit_busy_q;
      default: ;
    endcase
  end

  // keep the low digits of the group; digits above the converter width read as zero
  always_comb begin
    level_d = level_q;
    rows_d  = rows_q;
    score_d = score_q;
    if (commit_fire) begin
      case (grp_q)
        GRP_LEVEL: begin
          for (int i = 0; i < LEVEL_DIGITS; i++) level_d[i] = bcd_pad[i];
        end
        GRP_ROWS: begin
          for (int i = 0; i < ROWS_DIGITS; i++) rows_d[i] = bcd_pad[i];
        end
        GRP_SCORE: begin
          for (int i = 0; i < SCORE_DIGITS; i++) score_d[i] = bcd_pad[i];
        end
        default: ;
      endcase
    end
  end

  assign emit_adv  = emit_busy_q && (!out_valid_q || pop_i);
  assign emit_last = (emit_cnt_q == CNT_W'(TOTAL - 1));

  always_comb begin
    snap_d      = snap_q;
    emit_busy_d = emit_busy_q;
    emit_cnt_d  = emit_cnt_q;
    if (commit_fire) begin
      // chain order, most significant digit first within each group
      for (int i = 0; i < LEVEL_DIGITS; i++) begin
        snap_d[i] = level_d[LEVEL_DIGITS-1-i];
      end
      for (int i = 0; i < ROWS_DIGITS; i++) begin
        snap_d[LEVEL_DIGITS+i] = rows_d[ROWS_DIGITS-1-i];
      end
      for (int i = 0; i < SCORE_DIGITS; i++) begin
        snap_d[LEVEL_DIGITS+ROWS_DIGITS+i] = score_d[SCORE_DIGITS-1-i];
      end
      emit_busy_d = 1'b1;
      emit_cnt_d  = '0;
    end else if (emit_adv) begin
      snap_d     = {{DIGIT_W{1'b0}}, snap_q[TOTAL-1:1]};
      emit_cnt_d = emit_cnt_q + 1'b1;
      if (emit_last) begin
        emit_busy_d = 1'b0;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (emit_adv) begin
      out_valid_d = 1'b1;
    end else if (pop_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      iter_q      <= '0;
      level_q     <= '0;
      rows_q      <= '0;
      score_q     <= '0;
      emit_busy_q <= 1'b0;
      emit_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      level_q     <= level_d;
      rows_q      <= rows_d;
      score_q     <= score_d;
      emit_busy_q <= emit_busy_d;
      emit_cnt_q  <= emit_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (conv_load) begin
      bin_q <= q_rd_data_i.value;
      bcd_q <= '0;
      grp_q <= q_rd_data_i.grp;
    end else if (conv_step) begin
      bin_q <= {bin_q[VALUE_W-2:0], 1'b0};
      bcd_q <= {bcd_flat[CONV_DIGITS*DIGIT_W-2:0], bin_q[VALUE_W-1]};
    end
    snap_q <= snap_d;
    if (emit_adv) begin
      seg_q  <= seg_encode(snap_q[0]);
      slot_q <= SLOT_W'(emit_cnt_q);
      last_q <= emit_last;
    end
  end

  assign empty_o        = !out_valid_q;
  assign segment_byte_o = seg_q;
  assign digit_slot_o   = slot_q;
  assign last_o         = last_q;

endmodule

`default_nettype wire

FILE: sv/seven_segment_shift_chain_driver_unit.sv
// Top level of the seven-segment shift chain driver: front, command queue and back end.
// Depends on sssc_pkg, sssc_front, sssc_queue and sssc_back.
//
// Usage:
//   Input channel (push_i/full_o): each transaction sets the level, rows or score value by
//   opcode_i; new_value_i is binary and only the group's low decimal digits are kept.
//   Opcode 3 is taken and dropped without any output.
//   Output channel (empty_o/pop_i): every set produces LEVEL+ROWS+SCORE digit transactions
//   (12 by default), level group first, most significant digit first, digit_slot_o counting
//   from 0 and last_o on the final byte, after which the chain is latched.
//   Bytes leave one per cycle while pop_i keeps taking them. The bit-serial binary to decimal
//   converter takes one input bit per cycle between its load and commit states, and commits
//   only once the emitter is done with the previous set. Byte emission of one set overlaps
//   conversion of the next; a two-entry queue plus an input register buffer further sets.
//   Reset: all three values read as zero, queue and output are empty.
//   Output stall: bytes hold in the output register; once the emitter, the queue and the
//   input register are full, full_o rises and stays high until pop_i frees space.
`default_nettype none

module seven_segment_shift_chain_driver_unit #(
  parameter int LEVEL_DIGITS = sssc_pkg::LEVEL_DIGITS_DEF,
  parameter int ROWS_DIGITS  = sssc_pkg::ROWS_DIGITS_DEF,
  parameter int SCORE_DIGITS = sssc_pkg::SCORE_DIGITS_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push_i,
  output logic                               full_o,
  input  wire logic [sssc_pkg::OPCODE_W-1:0] opcode_i,
  input  wire logic [sssc_pkg::VALUE_W-1:0]  new_value_i,
  output logic                               empty_o,
  input  wire logic                          pop_i,
  output logic [sssc_pkg::SEG_W-1:0]         segment_byte_o,
  output logic [sssc_pkg::SLOT_W-1:0]        digit_slot_o,
  output logic                               last_o
);
  import sssc_pkg::*;

  q_status_t q_status;
  cmd_t      q_wr_data, q_rd_data;
  logic      q_push, q_pop;

  sssc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push_i),
    .full_o      (full_o),
    .opcode_i    (opcode_i),
    .new_value_i (new_value_i),
    .q_status_i  (q_status),
    .q_push_o    (q_push),
    .q_wr_data_o (q_wr_data)
  );

  sssc_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .wr_data_i (q_wr_data),
    .pop_i     (q_pop),
    .rd_data_o (q_rd_data),
    .status_o  (q_status)
  );

  sssc_back #(
    .LEVEL_DIGITS (LEVEL_DIGITS),
    .ROWS_DIGITS  (ROWS_DIGITS),
    .SCORE_DIGITS (SCORE_DIGITS)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_status_i     (q_status),
    .q_rd_data_i    (q_rd_data),
    .q_pop_o        (q_pop),
    .pop_i          (pop_i),
    .empty_o        (empty_o),
    .segment_byte_o (segment_byte_o),
    .digit_slot_o   (digit_slot_o),
    .last_o         (last_o)
  );

endmodule

`default_nettype wire

FILE: sv/sssc_checker.sv
// Port-level checks on the byte stream of the seven-segment shift chain driver, bound to the top.
// Depends on sssc_pkg.
`default_nettype none

module sssc_checker #(
  parameter int TOTAL_DIGITS = 12
) (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        empty_o,
  input wire logic                        pop_i,
  input wire logic [sssc_pkg::SEG_W-1:0]  segment_byte_o,
  input wire logic [sssc_pkg::SLOT_W-1:0] digit_slot_o,
  input wire logic                        last_o
);
  import sssc_pkg::*;

  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TOTAL_DIGITS - 1);

  // a taken byte that is not the last is followed at once by the next slot
  a_slot_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && !last_o) |=>
      (!empty_o && digit_slot_o == SLOT_W'($past(digit_slot_o) + 1'b1)))
    else $error("chain byte missing or out of order");

  // after the last byte a new chain starts at slot zero
  a_chain_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && pop_i && last_o) |=> (empty_o || digit_slot_o == '0))
    else $error("new chain does not start at slot zero");

  a_last_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && last_o) |-> (digit_slot_o == LAST_SLOT && !segment_byte_o[SEG_W-1]))
    else $error("last flag on wrong slot or decimal point lit");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty_o && !pop_i) |=>
      (!empty_o && $stable(segment_byte_o) && $stable(digit_slot_o) && $stable(last_o)))
    else $error("stalled transaction changed");

endmodule

bind seven_segment_shift_chain_driver_unit sssc_checker #(
  .TOTAL_DIGITS (LEVEL_DIGITS + ROWS_DIGITS + SCORE_DIGITS)
) u_sssc_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .empty_o        (empty_o),
  .pop_i          (pop_i),
  .segment_byte_o (segment_byte_o),
  .digit_slot_o   (digit_slot_o),
  .last_o         (last_o)
);

`default_nettype wire
